// ----- rtl/core/wsm_pkg.sv -----
// Shared types and constants for the wildcard stream matcher.
// Used by wsm_pattern, wsm_nfa and wildcard_stream_matcher; depends on nothing.
`default_nettype none

package wsm_pkg;

	localparam int MAX_PATTERN_DEF = 32;
	localparam int SYM_W           = 8;
	localparam int INDEX_W         = 16;
	localparam int OP_W            = 2;

	localparam logic [SYM_W-1:0]   WILD_ONE  = 8'h2E;
	localparam logic [SYM_W-1:0]   WILD_RUN  = 8'h2A;
	localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_START  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEXT   = 2'd2
	} opcode_t;

	typedef struct packed {
		logic             start;
		logic             append;
		logic             text;
		logic             last;
		logic [SYM_W-1:0] symbol;
	} wsm_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/wildcard_stream_matcher.sv -----
// Top level of the wildcard stream matcher: input register, command decode,
// word counter and result register. Depends on wsm_pkg, wsm_pattern and wsm_nfa.
//
//  Channel | Direction | tdata          | tuser       | tlast
//  s_*     | in        | symbol [7:0]   | opcode[1:0] | end_of_word
//  m_*     | out       | word_index[15:0] | matched   | none
//
// Every transaction passes through the input register, and each result
// then through the result register.
// One transaction is taken per cycle while no held result stalls it; the
// active position step is one parallel update over all pattern positions.
// Reset clears the pattern length, overflow flag and word count, and resets the positions to the start.
// A held result stalls only a transaction that would produce another result.
`default_nettype none

module wildcard_stream_matcher #(
	parameter int MaxPattern = wsm_pkg::MAX_PATTERN_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [wsm_pkg::SYM_W-1:0]     s_tdata,  // symbol[7:0]
	input  wire logic [wsm_pkg::OP_W-1:0]      s_tuser,  // opcode[1:0]
	input  wire logic                          s_tlast,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [wsm_pkg::INDEX_W-1:0]        m_tdata,  // word_index[15:0]
	output logic                               m_tuser   // matched
);
	import wsm_pkg::*;

	localparam int LEN_W = $clog2(MaxPattern + 1);

	logic               valid_s1;
	logic [OP_W-1:0]    op_s1;
	logic [SYM_W-1:0]   sym_s1;
	logic               eow_s1;
	logic               produce;
	logic               proceed;
	wsm_cmd_t           cmd;

	logic [MaxPattern-1:0][SYM_W-1:0] store;
	logic [LEN_W-1:0]                 length;
	logic [LEN_W-1:0]                 tail_start;
	logic                             overflow;
	logic                             hit;

	logic [INDEX_W-1:0] count_q;
	logic               out_valid_q;
	logic [INDEX_W-1:0] out_index_q;
	logic               out_match_q;

	always_comb begin
		cmd        = '0;
		cmd.symbol = sym_s1;
		cmd.last   = eow_s1;
		if (valid_s1) begin
			unique case (op_s1)
				OP_START:  cmd.start  = 1'b1;
				OP_APPEND: cmd.append = 1'b1;
				OP_TEXT:   cmd.text   = 1'b1;
				default:   ;
			endcase
		end
	end

	assign produce  = cmd.text && cmd.last;
	assign proceed  = !produce || !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || proceed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= s_tuser;
			sym_s1 <= s_tdata;
			eow_s1 <= s_tlast;
		end
	end

	wsm_cmd_t cmd_go;
	assign cmd_go = proceed ? cmd : '0;

	wsm_pattern #(
		.MaxPattern (MaxPattern),
		.LenW       (LEN_W)
	) u_pattern (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_go),
		.store      (store),
		.length     (length),
		.tail_start (tail_start),
		.overflow   (overflow)
	);

	wsm_nfa #(
		.MaxPattern (MaxPattern),
		.LenW       (LEN_W)
	) u_nfa (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_go),
		.store      (store),
		.length     (length),
		.tail_start (tail_start),
		.hit        (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd_go.start) begin
			count_q <= '0;
		end else if (cmd_go.text && cmd_go.last && count_q != INDEX_MAX) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proceed && produce) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && produce) begin
			out_index_q <= count_q;
			out_match_q <= hit && !overflow;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_index_q;
	assign m_tuser  = out_match_q;

endmodule

`default_nettype wire

// ----- rtl/core/wsm_pattern.sv -----
// Pattern store with length, trailing star run start and sticky overflow flag.
// Depends on wsm_pkg.
`default_nettype none

module wsm_pattern #(
	parameter int MaxPattern = wsm_pkg::MAX_PATTERN_DEF,
	parameter int LenW       = $clog2(MaxPattern + 1)
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire wsm_pkg::wsm_cmd_t                          cmd,
	output logic [MaxPattern-1:0][wsm_pkg::SYM_W-1:0]       store,
	output logic [LenW-1:0]                                 length,
	output logic [LenW-1:0]                                 tail_start,
	output logic                                            overflow
);
	import wsm_pkg::*;

	localparam int ADDR_W = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

	logic [MaxPattern-1:0][SYM_W-1:0] store_q;
	logic [LenW-1:0]                  len_q;
	logic [LenW-1:0]                  tail_q;
	logic                             ovf_q;
	logic                             room;
	logic [ADDR_W-1:0]                wr_addr;

	assign room    = len_q < LenW'(MaxPattern);
	assign wr_addr = len_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.append && room) begin
			store_q[wr_addr] <= cmd.symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			tail_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.start) begin
			len_q  <= '0;
			tail_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.append) begin
			if (room) begin
				len_q <= len_q + 1'b1;
				if (cmd.symbol != WILD_RUN) begin
					tail_q <= len_q + 1'b1;
				end
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign store      = store_q;
	assign length     = len_q;
	assign tail_start = tail_q;
	assign overflow   = ovf_q;

endmodule

`default_nettype wire

// ----- rtl/core/wsm_nfa.sv -----
// Active position vector of the pattern automaton and the per-character step.
// Depends on wsm_pkg and on the pattern state held by wsm_pattern.
`default_nettype none

module wsm_nfa #(
	parameter int MaxPattern = wsm_pkg::MAX_PATTERN_DEF,
	parameter int LenW       = $clog2(MaxPattern + 1)
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire wsm_pkg::wsm_cmd_t                     cmd,
	input  wire logic [MaxPattern-1:0][wsm_pkg::SYM_W-1:0] store,
	input  wire logic [LenW-1:0]                       length,
	input  wire logic [LenW-1:0]                       tail_start,
	output logic                                       hit
);
	import wsm_pkg::*;

	logic [MaxPattern:0]   active_q;
	logic [MaxPattern:0]   nxt;
	logic [MaxPattern:0]   acc;
	logic [MaxPattern-1:0] live;
	logic [MaxPattern-1:0] star;
	logic [MaxPattern-1:0] pass;

	always_comb begin
		for (int j = 0; j < MaxPattern; j++) begin
			live[j] = active_q[j] && (LenW'(j) < length);
			star[j] = store[j] == WILD_RUN;
			pass[j] = star[j] || store[j] == WILD_ONE || store[j] == cmd.symbol;
		end
		nxt[0] = live[0] && star[0];
		for (int j = 1; j < MaxPattern; j++) begin
			nxt[j] = (live[j] && star[j]) || (live[j-1] && pass[j-1]);
		end
		nxt[MaxPattern] = live[MaxPattern-1] && pass[MaxPattern-1];
		for (int j = 0; j <= MaxPattern; j++) begin
			acc[j] = (LenW'(j) >= tail_start) && (LenW'(j) <= length);
		end
	end

	assign hit = |(nxt & acc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= (MaxPattern + 1)'(1);
		end else if (cmd.start || cmd.append || (cmd.text && cmd.last)) begin
			active_q <= (MaxPattern + 1)'(1);
		end else if (cmd.text) begin
			active_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for wildcard_stream_matcher: directed table, then random patterns and
// words, then a short run of one-character words, checked by a behavioral model or typed rows.
// Depends on wsm_pkg and the matcher RTL.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import wsm_pkg::*;

	localparam int MAXP         = MAX_PATTERN_DEF;
	localparam int PHASE_ITEMS  = 600;
	localparam int SAT_WORDS    = 40;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 4;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [INDEX_W-1:0] idx;
		logic               hit;
	} word_result_t;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [SYM_W-1:0]   sym;
		logic               eow;
		bit                 typed;
		logic [INDEX_W-1:0] idx;
		logic               hit;
	} stim_row_t;

	localparam word_result_t NO_WANT = '0;

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [SYM_W-1:0]     s_tdata  = '0;
	logic [OP_W-1:0]      s_tuser  = '0;
	logic                 s_tlast  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [INDEX_W-1:0]   m_tdata;
	logic                 m_tuser;

	logic [SYM_W-1:0]     pat_chars [MAXP];
	int                   pat_len      = 0;
	logic [MAXP:0]        live_pos     = 1;
	logic [INDEX_W-1:0]   word_count   = '0;
	bit                   pat_over     = 1'b0;

	word_result_t         word_results_q [$];
	logic [SYM_W-1:0]     gen_pat [$];
	int                   send_idle    = 34;
	int                   recv_idle    = 84;
	int                   items_sent   = 0;
	int                   errors       = 0;
	int                   idle_cycles  = 0;

	stim_row_t directed_rows [24] = '{
		'{OP_TEXT,   8'h61, 1'b1, 1'b1, 16'd0, 1'b0},
		'{OP_UNUSED, 8'h7A, 1'b1, 1'b0, 16'd0, 1'b0},
		'{OP_START,  8'h00, 1'b1, 1'b0, 16'd0, 1'b0},
		'{OP_APPEND, 8'h61, 1'b1, 1'b0, 16'd0, 1'b0},
		'{OP_APPEND, WILD_ONE, 1'b0, 1'b0, 16'd0, 1'b0},
		'{OP_APPEND, WILD_RUN, 1'b0, 1'b0, 16'd0, 1'b0},
		'{OP_TEXT,   8'h61, 1'b0, 1'b0, 16'd0, 1'b0},
		'{OP_TEXT,   8'h78, 1'b0, 1'b0, 16'd0, 1'b0},
		'{OP_TEXT,   8'h62, 1'b1, 1'b0, 16'd0, 1'b0},
		'{OP_TEXT,   8'h61, 1'b0, 1'b0, 16'd0, 1'b0},
		'{OP_TEXT,   8'h78, 1'b1, 1'b0, 16'd0, 1'b0},
		'{OP_TEXT,   8'h61, 1'b1, 1'b0, 16'd0, 1'b0},
		'{OP_TEXT,   8'h61, 1'b0, 1'b0, 16'd0, 1'b0},
		'{OP_APPEND, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
		'{OP_TEXT,   8'h61, 1'b0, 1'b0, 16'd0, 1'b0},
		'{OP_TEXT,   8'hFF, 1'b0, 1'b0, 16'd0, 1'b0},
		'{OP_TEXT,   8'h71, 1'b0, 1'b0, 16'd0, 1'b0},
		'{OP_TEXT,   8'h00, 1'b1, 1'b0, 16'd0, 1'b0},
		'{OP_START,  8'hFF, 1'b0, 1'b0, 16'd0, 1'b0},
		'{OP_APPEND, 8'hFF, 1'b0, 1'b0, 16'd0, 1'b0},
		'{OP_TEXT,   8'hFF, 1'b1, 1'b1, 16'd0, 1'b1},
		'{OP_TEXT,   8'h00, 1'b1, 1'b1, 16'd1, 1'b0},
		'{OP_APPEND, WILD_RUN, 1'b0, 1'b0, 16'd0, 1'b0},
		'{OP_TEXT,   8'hFF, 1'b1, 1'b0, 16'd0, 1'b0}
	};

	wildcard_stream_matcher u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic bit advance_matcher(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
			input logic eow, output word_result_t res);
		logic [MAXP:0] nxt;
		logic [MAXP:0] acc;
		int            j;
		res = '0;
		case (op)
			OP_START: begin
				pat_len    = 0;
				pat_over   = 1'b0;
				word_count = '0;
				live_pos   = 1;
			end
			OP_APPEND: begin
				if (pat_len < MAXP) begin
					pat_chars[pat_len] = sym;
					pat_len++;
				end else begin
					pat_over = 1'b1;
				end
				live_pos = 1;
			end
			OP_TEXT: begin
				nxt = '0;
				for (j = 0; j < pat_len; j++) begin
					if (live_pos[j]) begin
						if (pat_chars[j] == WILD_RUN) begin
							nxt[j]   = 1'b1;
							nxt[j+1] = 1'b1;
						end else if (pat_chars[j] == WILD_ONE || pat_chars[j] == sym) begin
							nxt[j+1] = 1'b1;
						end
					end
				end
				live_pos = nxt;
				if (eow) begin
					acc          = '0;
					acc[pat_len] = 1'b1;
					j            = pat_len - 1;
					while (j >= 0 && pat_chars[j] == WILD_RUN) begin
						acc[j] = 1'b1;
						j--;
					end
					res.idx = word_count;
					res.hit = !pat_over && (|(live_pos & acc));
					if (word_count != INDEX_MAX)
						word_count++;
					live_pos = 1;
					return 1'b1;
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
			input logic eow, input bit typed, input word_result_t want);
		word_result_t got;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= sym;
		s_tlast  <= eow;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (advance_matcher(op, sym, eow, got))
			word_results_q.insert(word_results_q.size(), typed ? want : got);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (word_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [SYM_W-1:0] pick_pattern_char();
		int k;
		k = $urandom_range(9);
		if (k <= 2)
			return WILD_RUN;
		if (k <= 4)
			return WILD_ONE;
		if (k <= 8)
			return 8'h61 + SYM_W'($urandom_range(2));
		return SYM_W'($urandom_range(255));
	endfunction

	// One pattern (new or kept) followed by a few words, mostly built to fit the pattern.
	task automatic pattern_batch();
		logic [SYM_W-1:0] word [$];
		logic [SYM_W-1:0] ch;
		int               len;
		int               nwords;
		int               n;
		int               w;
		int               i;
		if ($urandom_range(7) != 0) begin
			send_item(OP_START, SYM_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, NO_WANT);
			gen_pat.delete();
			len = ($urandom_range(19) == 0) ? $urandom_range(30, 35) : $urandom_range(0, 8);
			for (i = 0; i < len; i++) begin
				ch = pick_pattern_char();
				send_item(OP_APPEND, ch, 1'($urandom_range(1)), 1'b0, NO_WANT);
				if (gen_pat.size() < MAXP)
					gen_pat.insert(gen_pat.size(), ch);
			end
		end
		nwords = $urandom_range(1, 6);
		for (w = 0; w < nwords; w++) begin
			word.delete();
			if ($urandom_range(9) == 0) begin
				n = $urandom_range(1, 6);
				repeat (n) word.insert(word.size(), SYM_W'($urandom_range(255)));
			end else begin
				foreach (gen_pat[i]) begin
					if (gen_pat[i] == WILD_RUN) begin
						n = $urandom_range(0, 3);
						repeat (n) word.insert(word.size(), 8'h61 + SYM_W'($urandom_range(2)));
					end else if (gen_pat[i] == WILD_ONE) begin
						word.insert(word.size(), 8'h61 + SYM_W'($urandom_range(3)));
					end else begin
						word.insert(word.size(), gen_pat[i]);
					end
				end
				if (word.size() != 0 && $urandom_range(3) == 0)
					word[$urandom_range(word.size() - 1)] = 8'h61 + SYM_W'($urandom_range(3));
				if (word.size() == 0 || $urandom_range(7) == 0)
					word.insert(word.size(), 8'h61 + SYM_W'($urandom_range(2)));
			end
			foreach (word[i]) begin
				if ($urandom_range(39) == 0)
					send_item(OP_UNUSED, SYM_W'($urandom_range(255)), 1'($urandom_range(1)),
						1'b0, NO_WANT);
				if ($urandom_range(59) == 0) begin
					ch = pick_pattern_char();
					send_item(OP_APPEND, ch, 1'($urandom_range(1)), 1'b0, NO_WANT);
					if (gen_pat.size() < MAXP)
						gen_pat.insert(gen_pat.size(), ch);
				end
				send_item(OP_TEXT, word[i], i == word.size() - 1, 1'b0, NO_WANT);
			end
		end
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin : result_check
		word_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (word_results_q.size() == 0) begin
				$error("unexpected result transaction: word_index %0d matched %0b", m_tdata, m_tuser);
				errors++;
			end else begin
				want = word_results_q.pop_front();
				if (m_tdata !== want.idx) begin
					$error("word_index: expected %0d, actual %0d", want.idx, m_tdata);
					errors++;
				end
				if (m_tuser !== want.hit) begin
					$error("matched: expected %0b, actual %0b", want.hit, m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int target;
		int phase;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_item(directed_rows[r].op, directed_rows[r].sym, directed_rows[r].eow,
				directed_rows[r].typed, '{idx: directed_rows[r].idx, hit: directed_rows[r].hit});
		wait_drained();

		for (phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 34 : (phase == 1) ? 84 : 0;
			recv_idle = (phase == 0) ? 84 : (phase == 1) ? 34 : 0;
			target    = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				pattern_batch();
			wait_drained();
		end

		send_item(OP_START, 8'h00, 1'b0, 1'b0, NO_WANT);
		send_item(OP_APPEND, WILD_ONE, 1'b0, 1'b0, NO_WANT);
		repeat (SAT_WORDS)
			send_item(OP_TEXT, SYM_W'($urandom_range(255)), 1'b1, 1'b0, NO_WANT);
		wait_drained();

		if (errors == 0 && word_results_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
